[sv/efl_pkg.sv]
// ----------------------------------------------------------------------------
// efl_pkg
// Shared types, codes and constants of the exact-fit free list.
// ----------------------------------------------------------------------------
package efl_pkg;

    localparam int DEF_MAX_FREE_NODES = 16;

    localparam int HANDLE_W  = 16;
    localparam int SIZE_W    = 24;
    localparam int BYTE_W    = 8;
    localparam int ALIGN_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;
    localparam int MASK_W    = 16;
    localparam int SUM_W     = SIZE_W + 2;
    localparam int WANT_W    = SIZE_W + 3;

    localparam logic [BYTE_W-1:0]  HEADER_RST   = 8'd16;
    localparam logic [BYTE_W-1:0]  DEADZONE_RST = 8'd0;
    localparam logic [ALIGN_W-1:0] ALIGN_RST    = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER   = 2'd0,
        CFG_DEADZONE = 2'd1,
        CFG_ALIGN    = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        REQ_FREE  = 1'b0,
        REQ_ALLOC = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FREED = 2'd0,
        STAT_HIT   = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } entry_t;

endpackage

[sv/efl_store.sv]
// ----------------------------------------------------------------------------
// efl_store
// Chunk storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module efl_store #(
    parameter int DEPTH = efl_pkg::DEF_MAX_FREE_NODES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  efl_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output efl_pkg::entry_t rdata
);
    import efl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/exact_fit_free_list.sv]
// ----------------------------------------------------------------------------
// exact_fit_free_list
// Ordered free list of chunks; free appends at the tail, allocate removes the
// oldest chunk whose size equals the padded and aligned request size.
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_stall  | req_type, node_handle,
//           |           |                    | node_chunk_size, request_size
//   out     | output    | out_valid/out_stall| status, granted_handle,
//           |           |                    | free_entries
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Free writes the new entry at the tail when there is room. Allocate reads one
// entry per cycle through the single read port and compare of the store, and
// on a hit moves each later entry down one place.
// One item at a time; in_stall stays high until the result is loaded into
// the output register, which holds while out_stall is high.
// Reset empties the list and restores the register defaults; no clear pass.
// ----------------------------------------------------------------------------
module exact_fit_free_list #(
    parameter int MAX_FREE_NODES = efl_pkg::DEF_MAX_FREE_NODES,
    parameter int CW             = $clog2(MAX_FREE_NODES + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [efl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efl_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic [efl_pkg::HANDLE_W-1:0]   node_handle,
    input  logic [efl_pkg::SIZE_W-1:0]     node_chunk_size,
    input  logic [efl_pkg::SIZE_W-1:0]     request_size,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [efl_pkg::STATUS_W-1:0]   status,
    output logic [efl_pkg::HANDLE_W-1:0]   granted_handle,
    output logic [CW-1:0]                  free_entries
);
    import efl_pkg::*;

    localparam int AW = $clog2(MAX_FREE_NODES);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE_NODES);

    state_t state_reg, state_next;

    logic [BYTE_W-1:0]   header_reg;
    logic [BYTE_W-1:0]   deadzone_reg;
    logic [ALIGN_W-1:0]  align_reg;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [WANT_W-1:0]   want_reg, want_next;
    status_t             res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [CW-1:0]       out_count_reg;

    logic                in_accept;
    logic                out_load;
    logic [CW-1:0]       ptr_inc;
    logic                match;
    logic                last;
    logic [MASK_W-1:0]   mask;

    logic                st_we;
    logic [AW-1:0]       st_waddr;
    entry_t              st_wdata;
    logic [AW-1:0]       st_raddr;
    entry_t              st_rdata;

    efl_store #(
        .DEPTH (MAX_FREE_NODES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign ptr_inc   = ptr_reg + 1'b1;
    assign match     = ({3'b000, st_rdata.size} == want_reg);
    assign last      = (ptr_inc == count_reg);
    assign mask      = (MASK_W'(1) << align_reg) - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (req_t'(req_type) == REQ_ALLOC) ? ST_PAD : ST_DONE;
                end
            end
            ST_PAD:
            begin
                state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = ST_SHIFT;
                end
                else if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (ptr_reg >= count_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        sum_next        = sum_reg;
        want_next       = want_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg;
        st_we           = 1'b0;
        st_waddr        = count_reg[AW-1:0];
        st_wdata        = '{handle: node_handle, size: node_chunk_size};
        st_raddr        = ptr_inc[AW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                sum_next = {2'b00, request_size} + SUM_W'(header_reg)
                         + SUM_W'(deadzone_reg);
                res_handle_next = '0;
                if (in_accept && req_t'(req_type) == REQ_FREE)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        st_we           = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = STAT_FREED;
                    end
                    else
                    begin
                        res_status_next = STAT_FULL;
                    end
                end
            end
            ST_PAD:
            begin
                want_next       = ({1'b0, sum_reg} + WANT_W'(mask)) & ~WANT_W'(mask);
                ptr_next        = '0;
                st_raddr        = '0;
                res_status_next = STAT_MISS;
            end
            ST_SCAN:
            begin
                ptr_next = ptr_inc;
                if (match)
                begin
                    res_status_next = STAT_HIT;
                    res_handle_next = st_rdata.handle;
                end
            end
            ST_SHIFT:
            begin
                if (ptr_reg < count_reg)
                begin
                    st_we    = 1'b1;
                    st_waddr = AW'(ptr_reg - 1'b1);
                    st_wdata = st_rdata;
                    ptr_next = ptr_inc;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            header_reg    <= HEADER_RST;
            deadzone_reg  <= DEADZONE_RST;
            align_reg     <= ALIGN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_HEADER:   header_reg   <= cfg_data;
                    CFG_DEADZONE: deadzone_reg <= cfg_data;
                    CFG_ALIGN:    align_reg    <= cfg_data[ALIGN_W-1:0];
                    default:      align_reg    <= align_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        sum_reg        <= sum_next;
        want_reg       <= want_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_handle = out_handle_reg;
    assign free_entries   = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("free list count above capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_status_reg == STAT_FULL) |-> (count_reg == MAX_CNT))
        else $error("full drop reported on a list with room");

    a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (ptr_reg != '0 && count_reg != '0
                                     && res_status_reg == STAT_HIT))
        else $error("compaction without a hit");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (ptr_reg < count_reg))
        else $error("scan beyond list tail");

endmodule

[test/tb_exact_fit_free_list.sv]
// ----------------------------------------------------------------------------
// tb_exact_fit_free_list
// Self-checking bench for the exact-fit free list. A queue of chunk requests
// feeds a driver that idles at random between beats. Each accepted beat runs
// through a shadow copy of the list and the padding registers to form the
// expected reply. A monitor stalls the reply channel at random and checks
// every reply field against the oldest expectation. Directed beats cover the
// empty, full, duplicate-size and oversized-padding cases. Random phases
// then fill and drain the list under several register settings, including
// the extremes.
// ----------------------------------------------------------------------------
module tb_exact_fit_free_list;
    import efl_pkg::*;

    localparam int FREE_SLOTS   = DEF_MAX_FREE_NODES;
    localparam int CNT_W        = $clog2(FREE_SLOTS + 1);
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 48;
    localparam int PHASE_ITEMS  = 125;
    localparam int MAX_PRINTS   = 100;

    typedef struct {
        req_t                kind;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   chunk;
        logic [SIZE_W-1:0]   bytes;
        int                  gap;
    } chunk_req_t;

    typedef struct {
        status_t             st;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    entries;
    } chunk_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 req_type;
    logic [HANDLE_W-1:0]  node_handle;
    logic [SIZE_W-1:0]    node_chunk_size;
    logic [SIZE_W-1:0]    request_size;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  granted_handle;
    logic [CNT_W-1:0]     free_entries;

    chunk_req_t   chunk_reqs[$];
    chunk_reply_t expected_replies[$];

    logic [HANDLE_W-1:0] shadow_handle [FREE_SLOTS];
    logic [SIZE_W-1:0]   shadow_size   [FREE_SLOTS];
    int                  shadow_count;
    logic [BYTE_W-1:0]   header_now;
    logic [BYTE_W-1:0]   deadzone_now;
    logic [ALIGN_W-1:0]  align_now;

    int beats_issued;
    int beats_taken;
    int replies_seen;
    int replies_drawn;
    int send_wait;
    int sink_wait;
    int idle_cycles;
    int mismatches;
    int settings_run;
    int n_freed;
    int n_hit;
    int n_miss;
    int n_full;
    bit sender_idles;
    bit sink_idles;

    exact_fit_free_list #(
        .MAX_FREE_NODES(FREE_SLOTS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .node_handle    (node_handle),
        .node_chunk_size(node_chunk_size),
        .request_size   (request_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .granted_handle (granted_handle),
        .free_entries   (free_entries)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] padded_bytes(input logic [SIZE_W-1:0] req_bytes,
                                                 input logic [BYTE_W-1:0] hdr,
                                                 input logic [BYTE_W-1:0] guard,
                                                 input logic [ALIGN_W-1:0] align);
        logic [63:0] sum;
        logic [63:0] mask;
        sum  = 64'(req_bytes) + 64'(hdr) + 64'(guard);
        mask = (64'd1 << align) - 64'd1;
        return (sum + mask) & ~mask;
    endfunction

    task automatic apply_to_free_list(input req_t kind, input logic [HANDLE_W-1:0] handle,
                                      input logic [SIZE_W-1:0] chunk,
                                      input logic [SIZE_W-1:0] req_bytes);
        chunk_reply_t reply;
        logic [63:0]  want;
        int           hit;
        reply.handle = '0;
        hit = -1;
        if (kind == REQ_FREE)
        begin
            if (shadow_count < FREE_SLOTS)
            begin
                shadow_handle[shadow_count] = handle;
                shadow_size[shadow_count]   = chunk;
                shadow_count++;
                reply.st = STAT_FREED;
            end
            else
                reply.st = STAT_FULL;
        end
        else
        begin
            want = padded_bytes(req_bytes, header_now, deadzone_now, align_now);
            reply.st = STAT_MISS;
            for (int i = 0; i < shadow_count; i++)
            begin
                if (hit < 0 && 64'(shadow_size[i]) == want)
                    hit = i;
            end
            if (hit >= 0)
            begin
                reply.handle = shadow_handle[hit];
                for (int j = hit; j < shadow_count - 1; j++)
                begin
                    shadow_handle[j] = shadow_handle[j + 1];
                    shadow_size[j]   = shadow_size[j + 1];
                end
                shadow_count--;
                reply.st = STAT_HIT;
            end
        end
        reply.entries = CNT_W'(shadow_count);
        expected_replies.push_back(reply);
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_item(input req_t kind, input logic [HANDLE_W-1:0] handle,
                              input logic [SIZE_W-1:0] chunk, input logic [SIZE_W-1:0] bytes);
        chunk_req_t item;
        item.kind   = kind;
        item.handle = handle;
        item.chunk  = chunk;
        item.bytes  = bytes;
        item.gap    = sender_idles ? $urandom_range(0, 13) : 0;
        chunk_reqs.push_back(item);
    endtask

    task automatic queue_free(input logic [HANDLE_W-1:0] handle, input logic [SIZE_W-1:0] chunk);
        queue_item(REQ_FREE, handle, chunk, SIZE_W'($urandom));
    endtask

    task automatic queue_alloc(input logic [SIZE_W-1:0] bytes);
        queue_item(REQ_ALLOC, HANDLE_W'($urandom), SIZE_W'($urandom), bytes);
    endtask

    task automatic wait_drained();
        while (chunk_reqs.size() != 0 || beats_issued != beats_taken
               || expected_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HEADER:   header_now   = val;
            CFG_DEADZONE: deadzone_now = val;
            CFG_ALIGN:    align_now    = val[ALIGN_W-1:0];
            default:      align_now    = align_now;
        endcase
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] guard,
                             input logic [ALIGN_W-1:0] align, input bit program_regs);
        logic [SIZE_W-1:0] classes [4];
        logic [63:0]       pad;
        logic [SIZE_W-1:0] bytes;
        bit                filling;
        int                k;
        wait_drained();
        if (program_regs)
        begin
            write_reg(CFG_HEADER, hdr);
            write_reg(CFG_DEADZONE, guard);
            write_reg(CFG_ALIGN, {4'($urandom_range(0, 15)), align});
        end
        settings_run++;
        for (int c = 0; c < 4; c++)
            classes[c] = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom)
                                                     : SIZE_W'($urandom_range(0, 200));
        filling = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i % 25 == 0)
            begin
                filling      = 1'($urandom_range(0, 1));
                sender_idles = ($urandom_range(0, 2) != 0);
            end
            k = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                queue_item(req_t'($urandom_range(0, 1)), HANDLE_W'($urandom),
                           SIZE_W'($urandom), SIZE_W'($urandom));
            else if ($urandom_range(0, 9) < (filling ? 7 : 3))
            begin
                pad = padded_bytes(classes[k], header_now, deadzone_now, align_now);
                queue_free(HANDLE_W'($urandom), pad[SIZE_W-1:0]);
            end
            else
            begin
                bytes = classes[k];
                if ($urandom_range(0, 3) == 0)
                    bytes = bytes + SIZE_W'($urandom_range(1, 3));
                queue_alloc(bytes);
            end
        end
    endtask

    always @(negedge clk)
    begin : drive_beats
        chunk_req_t nxt;
        if (rst_n && !(in_valid && beats_taken != beats_issued))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                in_valid <= 1'b0;
            end
            else if (chunk_reqs.size() != 0)
            begin
                nxt = chunk_reqs.pop_front();
                req_type        <= nxt.kind;
                node_handle     <= nxt.handle;
                node_chunk_size <= nxt.chunk;
                request_size    <= nxt.bytes;
                in_valid        <= 1'b1;
                send_wait       = nxt.gap;
                beats_issued++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            apply_to_free_list(req_t'(req_type), node_handle, node_chunk_size, request_size);
            beats_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (replies_drawn != replies_seen)
            begin
                replies_drawn = replies_seen;
                if ($urandom_range(0, 39) == 0)
                    sink_idles = !sink_idles;
                sink_wait = sink_idles ? $urandom_range(0, 13) : 0;
            end
            if (out_valid && sink_wait > 0)
            begin
                out_stall <= 1'b1;
                sink_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_replies
        chunk_reply_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            replies_seen++;
            if (expected_replies.size() == 0)
                note_mismatch($sformatf("reply with none pending: status %0d handle %h count %0d",
                                        status, granted_handle, free_entries));
            else
            begin
                exp_r = expected_replies.pop_front();
                if (status !== exp_r.st)
                    note_mismatch($sformatf("status %0d, want %0d", status, exp_r.st));
                if (granted_handle !== exp_r.handle)
                    note_mismatch($sformatf("granted_handle %h, want %h",
                                            granted_handle, exp_r.handle));
                if (free_entries !== exp_r.entries)
                    note_mismatch($sformatf("free_entries %0d, want %0d",
                                            free_entries, exp_r.entries));
                case (exp_r.st)
                    STAT_FREED: n_freed++;
                    STAT_HIT:   n_hit++;
                    STAT_MISS:  n_miss++;
                    STAT_FULL:  n_full++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("exact_fit_free_list verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_HEADER;
        cfg_data        = '0;
        in_valid        = 1'b0;
        req_type        = REQ_FREE;
        node_handle     = '0;
        node_chunk_size = '0;
        request_size    = '0;
        out_stall       = 1'b0;
        header_now      = HEADER_RST;
        deadzone_now    = DEADZONE_RST;
        align_now       = ALIGN_RST;
        shadow_count    = 0;
        sender_idles    = 1'b1;
        sink_idles      = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: header 16, no guard, 16-byte alignment
        queue_alloc(SIZE_W'(0));
        queue_free(16'h0000, 24'h000000);
        queue_free(16'hFFFF, 24'hFFFFFF);
        queue_free(16'h1234, 24'd16);
        queue_free(16'h2345, 24'd32);
        queue_free(16'h3456, 24'd16);
        queue_alloc(24'd0);
        queue_alloc(24'd1);
        queue_alloc(24'hFFFFFF);
        for (int k = 0; k < 13; k++)
            queue_free(HANDLE_W'($urandom), SIZE_W'(48 + 16 * k));
        queue_free(HANDLE_W'($urandom), 24'd999);
        queue_alloc(24'd224);
        queue_alloc(24'd0);

        run_phase(HEADER_RST, DEADZONE_RST, ALIGN_RST, 1'b0);
        run_phase(8'd0, 8'd0, 4'd0, 1'b1);
        run_phase(8'd255, 8'd255, 4'd12, 1'b1);
        run_phase(8'd255, 8'd255, 4'd15, 1'b1);
        run_phase(8'd0, 8'd255, 4'd1, 1'b1);
        run_phase(8'd255, 8'd0, 4'd8, 1'b1);
        for (int p = 0; p < 5; p++)
            run_phase(BYTE_W'($urandom), BYTE_W'($urandom), ALIGN_W'($urandom), 1'b1);
        run_phase(HEADER_RST, DEADZONE_RST, ALIGN_RST, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d requests across %0d register settings", beats_taken, settings_run);
        $display("replies: %0d stored, %0d exact hits, %0d misses, %0d dropped on a full list",
                 n_freed, n_hit, n_miss, n_full);
        if (mismatches == 0)
            $display("exact_fit_free_list verification clean");
        else
            $display("exact_fit_free_list verification failed");
        $finish;
    end

endmodule

[exact_fit_free_list.f]
sv/efl_pkg.sv
sv/efl_store.sv
sv/exact_fit_free_list.sv
test/tb_exact_fit_free_list.sv
